// ===== rtl/cscf_pkg.sv =====
// shared types and constants for the comment stripping character filter
package cscf_pkg;

   localparam int CharWidth         = 8;
   localparam int QueueDepthDefault = 4;

   localparam logic [CharWidth-1:0] CharSlash   = 8'h2F;
   localparam logic [CharWidth-1:0] CharQuote   = 8'h22;
   localparam logic [CharWidth-1:0] CharStar    = 8'h2A;
   localparam logic [CharWidth-1:0] CharNewline = 8'h0A;

   // one queue entry: a character and whether a held slash goes out before it
   typedef struct packed {
      logic [CharWidth-1:0] ch;
      logic                 pair;
   } cscf_entry_type;

   // front to queue write
   typedef struct packed {
      logic           valid;
      cscf_entry_type entry;
   } cscf_push_type;

endpackage

// ===== rtl/cscf_front.sv =====
// lexer front end: tracks comment and string mode and classifies each request
module cscf_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [cscf_pkg::CharWidth-1:0] in_char,
   output cscf_pkg::cscf_push_type        push
);
   import cscf_pkg::*;

   typedef enum logic [6:0] {
      MODE_PLAIN = 7'b0000001,
      MODE_SLASH = 7'b0000010,
      MODE_QUOTE = 7'b0000100,
      MODE_QEND  = 7'b0001000,
      MODE_LINE  = 7'b0010000,
      MODE_BLOCK = 7'b0100000,
      MODE_STAR  = 7'b1000000
   } mode_type;

   mode_type mode_ff, mode_in;
   logic     depth_ff, depth_in;
   logic     emit;
   logic     pair;

   function automatic mode_type plain_next(input logic [CharWidth-1:0] c);
      mode_type m;
      if (c == CharSlash) begin
         m = MODE_SLASH;
      end else if (c == CharQuote) begin
         m = MODE_QUOTE;
      end else begin
         m = MODE_PLAIN;
      end
      return m;
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      emit     = 1'b0;
      pair     = 1'b0;
      unique case (mode_ff)
         MODE_SLASH: begin
            if (in_char == CharSlash) begin
               mode_in = MODE_LINE;
            end else if (in_char == CharStar) begin
               mode_in  = MODE_BLOCK;
               depth_in = depth_ff + 1'b1;
            end else begin
               // held slash was not an opener: slash then this char
               mode_in = plain_next(in_char);
               emit    = 1'b1;
               pair    = 1'b1;
            end
         end
         MODE_QUOTE: begin
            if (in_char == CharQuote) begin
               mode_in = MODE_QEND;
            end
            emit = 1'b1;
         end
         MODE_QEND: begin
            if (in_char == CharQuote) begin
               mode_in = MODE_QUOTE;
               emit    = 1'b1;
            end else begin
               mode_in = plain_next(in_char);
               emit    = (in_char != CharSlash);
            end
         end
         MODE_LINE: begin
            if (in_char == CharNewline) begin
               mode_in = MODE_PLAIN;
               emit    = 1'b1;
            end
         end
         MODE_BLOCK: begin
            if (in_char == CharStar) begin
               mode_in = MODE_STAR;
            end
         end
         MODE_STAR: begin
            if (in_char == CharSlash) begin
               depth_in = depth_ff - 1'b1;
               mode_in  = (depth_ff == 1'b1) ? MODE_PLAIN : MODE_BLOCK;
            end else if (in_char != CharStar) begin
               mode_in = MODE_BLOCK;
            end
         end
         default: begin
            mode_in = plain_next(in_char);
            emit    = (in_char != CharSlash);
         end
      endcase
   end

   assign push.valid      = accept & emit;
   assign push.entry.ch   = in_char;
   assign push.entry.pair = pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         depth_ff <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         depth_ff <= depth_in;
      end
   end

endmodule

// ===== rtl/cscf_queue.sv =====
// short queue between the lexer front end and the output back end
module cscf_queue #(
   parameter int Depth = cscf_pkg::QueueDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cscf_pkg::cscf_push_type  push,
   input  logic                     pop,
   output logic                     full,
   output logic                     empty,
   output cscf_pkg::cscf_entry_type head
);
   import cscf_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

   cscf_entry_type        store_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == CntFull);
   assign empty   = (count_ff == '0);
   assign head    = store_ff[rd_ptr_ff];
   assign do_push = push.valid & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/cscf_back.sv =====
// output back end: expands a queued entry into one or two results
module cscf_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  cscf_pkg::cscf_entry_type       q_head,
   output logic                           q_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [cscf_pkg::CharWidth-1:0] rsp_out_char,
   output logic                           rsp_last_of_run
);
   import cscf_pkg::*;

   // set once the held slash of a pair entry has gone out
   logic second_ff, second_in;
   logic slash_first;
   logic taken;

   assign slash_first     = q_head.pair & ~second_ff;
   assign rsp_empty       = q_empty;
   assign rsp_out_char    = slash_first ? CharSlash : q_head.ch;
   assign rsp_last_of_run = ~slash_first;
   assign taken           = rsp_pop & ~q_empty;
   assign q_pop           = taken & ~slash_first;

   always_comb begin
      second_in = second_ff;
      if (taken) begin
         second_in = slash_first;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

// ===== rtl/comment_stripping_char_filter_core.sv =====
// comment stripping character filter: one character in, zero to two out
// results: queued when their request is accepted, shown on the rsp ports in request order
// throughput: one request per cycle while the queue has room; results leave one per
// cycle while rsp_pop is high, from the single back-end output, so a request giving two
// results holds its queue entry for both, and the queue absorbs the difference
// reset: lexer returns to plain text, depth to zero, queue and output stage emptied
module comment_stripping_char_filter_core #(
   parameter int QueueDepth = cscf_pkg::QueueDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [cscf_pkg::CharWidth-1:0] req_in_char,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [cscf_pkg::CharWidth-1:0] rsp_out_char,
   output logic                           rsp_last_of_run
);
   import cscf_pkg::*;

   cscf_push_type  push;
   cscf_entry_type head;
   logic           accept;
   logic           q_empty;
   logic           q_pop;

   assign accept = req_push & ~req_full;

   cscf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_char (req_in_char),
      .push    (push)
   );

   cscf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (q_pop),
      .full  (req_full),
      .empty (q_empty),
      .head  (head)
   );

   cscf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (head),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== verif/tb_comment_stripping_char_filter_core.sv =====
// testbench for the comment stripping character filter: random and directed source text
module tb_comment_stripping_char_filter_core;
   import cscf_pkg::*;

   localparam int HalfPeriod     = 5;
   localparam int ResetCycles    = 5;
   localparam int HoldCycles     = 150;
   localparam int StallLimit     = 3000;
   localparam int SettleCycles   = 4;
   localparam int PhaseRequests  = 530;

   typedef enum logic [2:0] {
      ModePlain    = 3'd0,
      ModeSlash    = 3'd1,
      ModeQuote    = 3'd2,
      ModeQuoteEnd = 3'd3,
      ModeLine     = 3'd4,
      ModeBlock    = 3'd5,
      ModeStar     = 3'd6
   } lexer_mode_type;

   typedef struct {
      logic [CharWidth-1:0] ch;
      logic                 is_last;
   } stripped_char_type;

   // tracks the lexer state and the characters that must come out, in order
   class stripped_text_checker;
      lexer_mode_type    mode;
      logic              depth;
      stripped_char_type pending_chars[$];
      int                errors;

      function new();
         mode   = ModePlain;
         depth  = 1'b0;
         errors = 0;
      endfunction

      function void add_char(logic [CharWidth-1:0] ch, logic is_last);
         stripped_char_type item;
         item.ch      = ch;
         item.is_last = is_last;
         pending_chars.push_back(item);
      endfunction

      // plain text handling; returns 1 when the character goes out
      function bit plain_step(logic [CharWidth-1:0] c);
         if (c == CharSlash) begin
            mode = ModeSlash;
            return 1'b0;
         end
         mode = (c == CharQuote) ? ModeQuote : ModePlain;
         return 1'b1;
      endfunction

      function int note_source_char(logic [CharWidth-1:0] c);
         int n;
         n = 0;
         case (mode)
            ModeSlash: begin
               if (c == CharSlash) begin
                  mode = ModeLine;
               end else if (c == CharStar) begin
                  mode  = ModeBlock;
                  depth = depth + 1'b1;
               end else begin
                  void'(plain_step(c));
                  add_char(CharSlash, 1'b0);
                  add_char(c, 1'b1);
                  n = 2;
               end
            end
            ModeQuote: begin
               if (c == CharQuote) mode = ModeQuoteEnd;
               n = 1;
            end
            ModeQuoteEnd: begin
               if (c == CharQuote) begin
                  mode = ModeQuote;
                  n = 1;
               end else begin
                  n = plain_step(c) ? 1 : 0;
               end
            end
            ModeLine: begin
               if (c == CharNewline) begin
                  mode = ModePlain;
                  n = 1;
               end
            end
            ModeBlock: begin
               if (c == CharStar) mode = ModeStar;
            end
            ModeStar: begin
               if (c == CharSlash) begin
                  depth = depth - 1'b1;
                  mode  = (depth == 1'b0) ? ModePlain : ModeBlock;
               end else if (c != CharStar) begin
                  mode = ModeBlock;
               end
            end
            default: begin
               n = plain_step(c) ? 1 : 0;
            end
         endcase
         if (n == 1) add_char(c, 1'b1);
         return n;
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_stripped_char(logic [CharWidth-1:0] ch, logic is_last);
         stripped_char_type want;
         if (pending_chars.size() == 0) begin
            report($sformatf("unexpected result char %02h last %0b", ch, is_last));
            return;
         end
         want = pending_chars.pop_front();
         if (ch !== want.ch)
            report($sformatf("out_char %02h, expected %02h", ch, want.ch));
         if (is_last !== want.is_last)
            report($sformatf("last_of_run %0b on char %02h, expected %0b",
                             is_last, want.ch, want.is_last));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   logic [CharWidth-1:0] req_in_char;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic [CharWidth-1:0] rsp_out_char;
   logic                 rsp_last_of_run;

   stripped_text_checker checker_h;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  sent_requests;
   int  quiet_cycles;
   bit  hold_rsp;

   comment_stripping_char_filter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_char    (req_in_char),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_char   (rsp_out_char),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always #HalfPeriod clock = ~clock;

   // results are checked before the request of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) checker_h.check_stripped_char(rsp_out_char, rsp_last_of_run);
         if (req_push && !req_full) begin
            void'(checker_h.note_source_char(req_in_char));
            sent_requests++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("FAIL comment_stripping_char_filter_core");
            $finish;
         end
      end
   end

   // result side: random pops, with one long hold-off on request
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_pop <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_char(logic [CharWidth-1:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push    <= 1'b1;
      req_in_char <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_push <= 1'b0;
      @(negedge clock);
      while (checker_h.pending_chars.size() != 0) @(negedge clock);
   endtask

   function automatic logic [CharWidth-1:0] text_byte();
      logic [CharWidth-1:0] c;
      do c = CharWidth'($urandom_range(255));
      while (c == CharSlash || c == CharQuote);
      return c;
   endfunction

   task automatic send_random_token();
      int kind;
      int len;
      kind = $urandom_range(99);
      len  = $urandom_range(6);
      if (kind < 20) begin
         repeat ($urandom_range(1, 4)) send_char(CharWidth'($urandom_range(255)));
      end else if (kind < 40) begin
         repeat (len + 1) send_char(text_byte());
      end else if (kind < 55) begin
         send_char(CharQuote);
         repeat (len) begin
            if ($urandom_range(7) == 0) begin
               send_char(CharQuote);
               send_char(CharQuote);
            end else begin
               send_char(text_byte());
            end
         end
         send_char(CharQuote);
      end else if (kind < 67) begin
         send_char(CharSlash);
         send_char(CharSlash);
         repeat (len) send_char(($urandom_range(3) == 0) ? CharSlash : text_byte());
         send_char(CharNewline);
      end else if (kind < 82) begin
         send_char(CharSlash);
         send_char(CharStar);
         repeat (len) begin
            if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_char(CharStar);
            send_char(text_byte());
         end
         repeat ($urandom_range(1, 3)) send_char(CharStar);
         send_char(CharSlash);
      end else begin
         // held slash followed by a quote or a text byte, which opens no comment unless it is a star
         send_char(CharSlash);
         send_char(($urandom_range(3) == 0) ? CharQuote : text_byte());
      end
   endtask

   task automatic run_random_phase(int requests);
      int start;
      start = sent_requests;
      while (sent_requests - start < requests) send_random_token();
   endtask

   initial begin
      logic [CharWidth-1:0] directed[$];
      checker_h           = new();
      reset               = 1'b1;
      req_push            = 1'b0;
      req_in_char         = '0;
      send_idle_pct       = 0;
      recv_idle_pct       = 0;
      hold_rsp            = 1'b0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // plain extremes, slash pairs, doubled quote, slash after a closed string,
      // line comment, block comment closed by a star run
      directed = '{8'h61, 8'h00, 8'hFF, CharStar, CharNewline,
                   CharSlash, 8'h78, CharSlash, CharQuote, 8'h61, CharQuote, CharQuote,
                   8'h62, CharQuote, CharSlash, CharSlash, 8'h7A, CharNewline,
                   CharSlash, CharStar, 8'h71, CharStar, CharStar, CharSlash, 8'h80};
      foreach (directed[i]) send_char(directed[i]);
      wait_until_drained();

      send_idle_pct = 17;
      recv_idle_pct = 82;
      run_random_phase(PhaseRequests);
      wait_until_drained();

      send_idle_pct = 82;
      recv_idle_pct = 17;
      run_random_phase(PhaseRequests);
      wait_until_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_rsp      = 1'b1;
      run_random_phase(PhaseRequests);
      wait_until_drained();

      repeat (SettleCycles) @(posedge clock);
      if (checker_h.pending_chars.size() != 0)
         checker_h.report($sformatf("%0d results never arrived",
                                    checker_h.pending_chars.size()));
      if (checker_h.errors == 0) begin
         $display("PASS comment_stripping_char_filter_core");
      end else begin
         $display("FAIL comment_stripping_char_filter_core");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/cscf_pkg.sv
rtl/cscf_front.sv
rtl/cscf_queue.sv
rtl/cscf_back.sv
rtl/comment_stripping_char_filter_core.sv
verif/tb_comment_stripping_char_filter_core.sv
